>>> hdl/osp_pkg.sv
`default_nettype none
package osp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TEXT,
    ST_SEMI,
    ST_COLON,
    ST_SPACE,
    ST_DIGIT,
    ST_FINISH
  } osp_state_t;

  localparam logic [2:0] KIND_BELL    = 3'd0;
  localparam logic [2:0] KIND_PROMPT  = 3'd1;
  localparam logic [2:0] KIND_COMMAND = 3'd2;
  localparam logic [2:0] KIND_EXEC    = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;
  localparam logic [2:0] KIND_NOTIFY  = 3'd5;
  localparam logic [2:0] KIND_TITLE   = 3'd6;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_OSC   = 8'h5D;  // ']'
  localparam logic [7:0] CH_BSL   = 8'h5C;  // '\'
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;

  localparam logic [8*4-1:0]  PFX_MARK   = "133;";
  localparam logic [8*11-1:0] PFX_NOTIFY = "777;notify;";

  localparam int          HEAD_BYTES = 12;
  localparam logic [17:0] CODE_NONE  = 18'h3FFFF;
  localparam logic [16:0] DONE_CLAMP = 17'd100000;

endpackage
`default_nettype wire

>>> hdl/osp_ram.sv
`default_nettype none
module osp_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/osc_mark_stream_parser.sv
`default_nettype none
// Channel  Dir  tdata (low bit up)                                tlast           tuser
// in_      in   data_byte[7:0]                                    last_in_buffer  -
// out_     out  exit_code[17:0] end_offset[49:18] text_char[57:50] last_of_hit    mark_kind[2:0]
//                                                                                 text_valid[3]
// Ordinary bytes are taken whenever the parser is idle. A string terminator
// stops intake while the stored payload is scanned through the single-port read
// of the payload RAM: a read step, then a text or digit step, per scanned byte;
// a step per inserted ':' and ' ', a check step for the byte after the 777 title
// ';', and a closing step. A bell outside a string takes the closing step only.
// Back-pressure on out_ stalls the text, ':', ' ' and closing steps.
// Synchronous active-low reset clears the OSC/ESC state, length and offset;
// the payload RAM is not cleared (reads past the length count as zero).
module osc_mark_stream_parser #(
  parameter int PAYLOAD_BYTES = 256,
  parameter int TEXT_BYTES    = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte[7:0]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,  // exit_code, end_offset, text_char, zero pad
  output logic      [3:0]  out_tuser,  // mark_kind[2:0], text_valid
  output logic             out_tlast
);
  import osp_pkg::*;

  localparam int AW = $clog2(PAYLOAD_BYTES);
  localparam int CW = $clog2(TEXT_BYTES);
  localparam logic [AW-1:0] LEN_MAX = AW'(PAYLOAD_BYTES - 1);
  localparam logic [CW-1:0] CNT_CAP = CW'(TEXT_BYTES - 1);

  // control state
  osp_state_t      st_r, st_nxt, ret_r, ret_nxt;
  logic            in_osc_r, in_osc_nxt;
  logic            esc_r, esc_nxt;
  logic [AW-1:0]   len_r, len_nxt;
  logic            ovf_r, ovf_nxt;
  logic [31:0]     off_r, off_nxt;
  // scan state
  logic [AW-1:0]   a_r, a_nxt;
  logic            stop_r, stop_nxt;       // 777 title stops at ';'
  logic [2:0]      kind_r, kind_nxt;
  logic [17:0]     code_r, code_nxt;
  logic [31:0]     end_r, end_nxt;
  logic [7:0]      pend_r, pend_nxt;       // held char, one beat of lookahead
  logic            pend_v_r, pend_v_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [7:0]      head_r [HEAD_BYTES];
  // output register
  logic            ov_r;
  logic [2:0]      o_kind_r;
  logic [17:0]     o_code_r;
  logic [31:0]     o_end_r;
  logic [7:0]      o_char_r;
  logic            o_tv_r, o_last_r;

  logic            ld, ld_tv, ld_last;
  logic [7:0]      ld_char;
  logic            ram_we, ram_re;
  logic [7:0]      rd_data, d, b;
  logic            acc, out_free, can_put, full;
  logic [31:0]     end_now;
  logic [7:0]      hb [HEAD_BYTES];
  logic            is_mark, is_nine, is_nine4, is_777, is_title;
  logic [16:0]     v_prev;
  logic [20:0]     v_new;

  osp_ram #(.DEPTH(PAYLOAD_BYTES), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (a_r),
    .rdata (rd_data)
  );

  assign in_tready = (st_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign out_free  = !ov_r || out_tready;
  assign can_put   = !pend_v_r || out_free;
  assign full      = (cnt_r == CNT_CAP);
  assign d         = (a_r < len_r) ? rd_data : 8'h00;
  assign end_now   = (off_r == 32'hFFFF_FFFF) ? off_r : off_r + 32'd1;
  assign ram_we    = acc && in_osc_r && !esc_r && b != CH_BEL && b != CH_ESC
                     && len_r < LEN_MAX;
  assign ram_re    = (st_r == ST_READ);

  // first payload bytes, zero past the length
  always_comb begin
    for (int k = 0; k < HEAD_BYTES; k++) begin
      hb[k] = (AW'(k) < len_r) ? head_r[k] : 8'h00;
    end
  end

  always_comb begin
    is_mark = !ovf_r;
    for (int k = 0; k < 4; k++) begin
      if (hb[k] != PFX_MARK[8*(3-k) +: 8]) is_mark = 1'b0;
    end
    is_777 = 1'b1;
    for (int k = 0; k < 11; k++) begin
      if (hb[k] != PFX_NOTIFY[8*(10-k) +: 8]) is_777 = 1'b0;
    end
    is_nine  = (hb[0] == CH_NINE) && (hb[1] == CH_SEMI);
    is_nine4 = (hb[2] == CH_FOUR) && (hb[3] == CH_SEMI);
    is_title = (hb[0] == CH_ZERO || hb[0] == CH_TWO) && (hb[1] == CH_SEMI);
  end

  assign v_prev = (code_r == CODE_NONE) ? 17'd0 : code_r[16:0];
  assign v_new  = {4'd0, v_prev} * 21'd10 + {13'd0, d - CH_ZERO};

  always_comb begin
    st_nxt     = st_r;
    ret_nxt    = ret_r;
    in_osc_nxt = in_osc_r;
    esc_nxt    = esc_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    off_nxt    = off_r;
    a_nxt      = a_r;
    stop_nxt   = stop_r;
    kind_nxt   = kind_r;
    code_nxt   = code_r;
    end_nxt    = end_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    cnt_nxt    = cnt_r;
    ld         = 1'b0;
    ld_char    = pend_r;
    ld_tv      = 1'b1;
    ld_last    = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          off_nxt    = in_tlast ? 32'd0 : end_now;
          end_nxt    = end_now;
          code_nxt   = CODE_NONE;
          pend_v_nxt = 1'b0;
          cnt_nxt    = '0;
          stop_nxt   = 1'b0;
          if (!in_osc_r) begin
            if (esc_r) begin
              esc_nxt = (b == CH_ESC);
              if (b == CH_OSC) begin
                in_osc_nxt = 1'b1;
                len_nxt    = '0;
                ovf_nxt    = 1'b0;
              end
            end else if (b == CH_ESC) begin
              esc_nxt = 1'b1;
            end else if (b == CH_BEL) begin
              kind_nxt = KIND_BELL;
              st_nxt   = ST_FINISH;
            end
          end else if ((esc_r && b == CH_BSL) || (!esc_r && b == CH_BEL)) begin
            // terminator: classify the payload
            esc_nxt = 1'b0;
            if (is_mark) begin
              if (hb[4] == CH_A || hb[4] == CH_B || hb[4] == CH_C) begin
                kind_nxt = (hb[4] == CH_A) ? KIND_PROMPT :
                           (hb[4] == CH_B) ? KIND_COMMAND : KIND_EXEC;
                st_nxt   = ST_FINISH;
              end else if (hb[4] == CH_D) begin
                kind_nxt = KIND_DONE;
                if (hb[5] == CH_SEMI) begin
                  a_nxt   = AW'(6);
                  ret_nxt = ST_DIGIT;
                  st_nxt  = ST_READ;
                end else begin
                  st_nxt = ST_FINISH;
                end
              end else begin
                in_osc_nxt = 1'b0;
                len_nxt    = '0;
                ovf_nxt    = 1'b0;
              end
            end else if ((is_nine && !is_nine4) || is_title) begin
              kind_nxt = is_nine ? KIND_NOTIFY : KIND_TITLE;
              a_nxt    = AW'(2);
              ret_nxt  = ST_TEXT;
              st_nxt   = ST_READ;
            end else if (is_777 && !is_nine) begin
              kind_nxt = KIND_NOTIFY;
              stop_nxt = 1'b1;
              a_nxt    = AW'(11);
              ret_nxt  = ST_TEXT;
              st_nxt   = ST_READ;
            end else begin
              in_osc_nxt = 1'b0;
              len_nxt    = '0;
              ovf_nxt    = 1'b0;
            end
          end else if (esc_r) begin
            // stray ESC abandons the string
            esc_nxt    = 1'b0;
            in_osc_nxt = 1'b0;
            len_nxt    = '0;
            ovf_nxt    = 1'b0;
          end else if (b == CH_ESC) begin
            esc_nxt = 1'b1;
          end else if (len_r < LEN_MAX) begin
            len_nxt = len_r + AW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        st_nxt = ret_r;
      end
      ST_TEXT: begin
        if (d == 8'h00 || full) begin
          st_nxt = ST_FINISH;
        end else if (stop_r && d == CH_SEMI) begin
          a_nxt   = a_r + AW'(1);
          ret_nxt = ST_SEMI;
          st_nxt  = ST_READ;
        end else if (can_put) begin
          ld         = pend_v_r;
          pend_nxt   = d;
          pend_v_nxt = 1'b1;
          cnt_nxt    = cnt_r + CW'(1);
          a_nxt      = a_r + AW'(1);
          ret_nxt    = ST_TEXT;
          st_nxt     = ST_READ;
        end
      end
      ST_SEMI: begin
        if (d == 8'h00) begin
          st_nxt = ST_FINISH;
        end else begin
          stop_nxt = 1'b0;
          st_nxt   = ST_COLON;
        end
      end
      ST_COLON, ST_SPACE: begin
        if (full) begin
          st_nxt = ST_FINISH;
        end else if (can_put) begin
          ld         = pend_v_r;
          pend_nxt   = (st_r == ST_COLON) ? CH_COLON : CH_SPACE;
          pend_v_nxt = 1'b1;
          cnt_nxt    = cnt_r + CW'(1);
          st_nxt     = (st_r == ST_COLON) ? ST_SPACE : ST_TEXT;
        end
      end
      ST_DIGIT: begin
        if (d >= CH_ZERO && d <= CH_NINE) begin
          if (v_new > {4'd0, DONE_CLAMP}) begin
            code_nxt = {1'b0, DONE_CLAMP};
            st_nxt   = ST_FINISH;
          end else begin
            code_nxt = {1'b0, v_new[16:0]};
            a_nxt    = a_r + AW'(1);
            ret_nxt  = ST_DIGIT;
            st_nxt   = ST_READ;
          end
        end else begin
          st_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          ld         = 1'b1;
          ld_char    = pend_v_r ? pend_r : 8'h00;
          ld_tv      = pend_v_r;
          ld_last    = 1'b1;
          in_osc_nxt = 1'b0;
          esc_nxt    = 1'b0;
          len_nxt    = '0;
          ovf_nxt    = 1'b0;
          st_nxt     = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      ret_r    <= ST_IDLE;
      in_osc_r <= 1'b0;
      esc_r    <= 1'b0;
      len_r    <= '0;
      ovf_r    <= 1'b0;
      off_r    <= '0;
      pend_v_r <= 1'b0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      ret_r    <= ret_nxt;
      in_osc_r <= in_osc_nxt;
      esc_r    <= esc_nxt;
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      off_r    <= off_nxt;
      pend_v_r <= pend_v_nxt;
      cnt_r    <= cnt_nxt;
      if (ld) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    stop_r <= stop_nxt;
    kind_r <= kind_nxt;
    code_r <= code_nxt;
    end_r  <= end_nxt;
    pend_r <= pend_nxt;
    if (ram_we && len_r < AW'(HEAD_BYTES)) begin
      head_r[len_r[$clog2(HEAD_BYTES)-1:0]] <= b;
    end
    if (ld) begin
      o_kind_r <= kind_r;
      o_code_r <= code_r;
      o_end_r  <= end_r;
      o_char_r <= ld_char;
      o_tv_r   <= ld_tv;
      o_last_r <= ld_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, o_char_r, o_end_r, o_code_r};
  assign out_tuser  = {o_tv_r, o_kind_r};
  assign out_tlast  = o_last_r;

endmodule
`default_nettype wire

>>> test/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import osp_pkg::*;

  localparam int PAYLOAD_BYTES = 256;
  localparam int TEXT_BYTES    = 64;
  localparam int CYCLE_LIMIT   = 1500000;

  // Expected hit beat, in output field order.
  typedef struct packed {
    logic [2:0]  kind;
    logic [17:0] code;
    logic [31:0] end_off;
    logic [7:0]  ch;
    logic        ch_valid;
    logic        last;
  } hit_beat_t;

  // Pending input beat: byte plus last-in-buffer flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } term_beat_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [63:0] out_tdata;
  logic [3:0]  out_tuser;

  osc_mark_stream_parser #(.PAYLOAD_BYTES(PAYLOAD_BYTES), .TEXT_BYTES(TEXT_BYTES)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  term_beat_t byte_queue[$];
  hit_beat_t  hit_queue[$];
  int errors = 0;
  int cycles = 0;

  // Shadow copy of the scanner state.
  bit          sh_in_osc, sh_esc;
  logic [7:0]  sh_payload[PAYLOAD_BYTES];
  int          sh_len;
  bit          sh_ovf;
  logic [31:0] sh_offset;
  logic [7:0]  sh_text[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic [7:0] pay_at(int i);
    if (i >= sh_len) return 8'h00;
    return sh_payload[i];
  endfunction

  function automatic void text_put(logic [7:0] c);
    if (sh_text.size() < TEXT_BYTES - 1) sh_text.push_back(c);
  endfunction

  // Copy payload into text until zero byte (or stop char); return stop index.
  function automatic int text_copy(int i, logic [7:0] stop, bit use_stop);
    logic [7:0] c;
    c = pay_at(i);
    while (c != 0 && !(use_stop && c == stop)) begin
      text_put(c);
      i++;
      c = pay_at(i);
    end
    return i;
  endfunction

  function automatic logic [17:0] done_code(int i);
    int v;
    logic [7:0] c;
    v = 0;
    c = pay_at(i);
    if (c < CH_ZERO || c > CH_NINE) return CODE_NONE;
    while (c >= CH_ZERO && c <= CH_NINE) begin
      v = v * 10 + (c - CH_ZERO);
      if (v > DONE_CLAMP) begin
        v = int'(DONE_CLAMP);
        break;
      end
      i++;
      c = pay_at(i);
    end
    return v[17:0];
  endfunction

  function automatic bit has_prefix(string s);
    for (int k = 0; k < s.len(); k++)
      if (pay_at(k) != s[k]) return 0;
    return 1;
  endfunction

  // Classify the finished payload; 1 on a hit.
  function automatic bit classify_payload(output logic [2:0] kind, output logic [17:0] code);
    int semi;
    code = CODE_NONE;
    kind = KIND_BELL;
    sh_text.delete();
    if (!sh_ovf && sh_len >= 5 && has_prefix("133;")) begin
      case (pay_at(4))
        CH_A: begin kind = KIND_PROMPT;  return 1; end
        CH_B: begin kind = KIND_COMMAND; return 1; end
        CH_C: begin kind = KIND_EXEC;    return 1; end
        CH_D: begin
          kind = KIND_DONE;
          if (sh_len >= 6 && pay_at(5) == CH_SEMI) code = done_code(6);
          return 1;
        end
        default: return 0;
      endcase
    end
    if (sh_len >= 2 && has_prefix("9;")) begin
      if (pay_at(2) == CH_FOUR && pay_at(3) == CH_SEMI) return 0;
      kind = KIND_NOTIFY;
      void'(text_copy(2, 0, 0));
      return 1;
    end
    if (sh_len >= 11 && has_prefix("777;notify;")) begin
      kind = KIND_NOTIFY;
      semi = text_copy(11, CH_SEMI, 1);
      if (pay_at(semi) == CH_SEMI && pay_at(semi + 1) != 0) begin
        text_put(CH_COLON);
        text_put(CH_SPACE);
        void'(text_copy(semi + 1, 0, 0));
      end
      return 1;
    end
    if (sh_len >= 2 && (pay_at(0) == CH_ZERO || pay_at(0) == CH_TWO) && pay_at(1) == CH_SEMI) begin
      kind = KIND_TITLE;
      void'(text_copy(2, 0, 0));
      return 1;
    end
    return 0;
  endfunction

  function automatic void push_hit(logic [2:0] kind, logic [17:0] code, logic [31:0] end_off);
    hit_beat_t h;
    int n;
    n = (sh_text.size() != 0) ? sh_text.size() : 1;
    for (int k = 0; k < n; k++) begin
      h.kind     = kind;
      h.code     = code;
      h.end_off  = end_off;
      h.ch       = (sh_text.size() != 0) ? sh_text[k] : 8'h00;
      h.ch_valid = (sh_text.size() != 0);
      h.last     = (k == n - 1);
      hit_queue.push_back(h);
    end
  endfunction

  function automatic void close_osc();
    sh_in_osc = 0;
    sh_esc = 0;
    sh_len = 0;
    sh_ovf = 0;
  endfunction

  // Advance the shadow state by one accepted byte.
  function automatic void predict_byte(logic [7:0] b, logic last);
    logic [31:0] end_off;
    logic [2:0]  kind;
    logic [17:0] code;
    end_off = (sh_offset == 32'hFFFF_FFFF) ? sh_offset : sh_offset + 32'd1;
    sh_offset = last ? 32'd0 : end_off;
    if (!sh_in_osc) begin
      if (sh_esc) begin
        sh_esc = 0;
        if (b == CH_OSC) begin
          sh_in_osc = 1;
          sh_len = 0;
          sh_ovf = 0;
        end else if (b == CH_ESC) begin
          sh_esc = 1;
        end
      end else if (b == CH_ESC) begin
        sh_esc = 1;
      end else if (b == CH_BEL) begin
        sh_text.delete();
        push_hit(KIND_BELL, CODE_NONE, end_off);
      end
      return;
    end
    if (sh_esc) begin
      // ESC-backslash terminates; anything else abandons the string
      if (b == CH_BSL && classify_payload(kind, code)) push_hit(kind, code, end_off);
      close_osc();
      return;
    end
    if (b == CH_BEL) begin
      if (classify_payload(kind, code)) push_hit(kind, code, end_off);
      close_osc();
      return;
    end
    if (b == CH_ESC) begin
      sh_esc = 1;
      return;
    end
    if (sh_len < PAYLOAD_BYTES - 1) begin
      sh_payload[sh_len] = b;
      sh_len++;
    end else begin
      sh_ovf = 1;
    end
  endfunction

  // ---- stimulus helpers ----
  function automatic void put_byte(logic [7:0] b);
    term_beat_t t;
    t.data = b;
    t.last = ($urandom_range(0, 15) == 0);
    byte_queue.push_back(t);
  endfunction

  function automatic void put_str(string s);
    for (int k = 0; k < s.len(); k++) put_byte(s[k]);
  endfunction

  // Wrap a payload in ESC ] ... and a random terminator (BEL or ESC-backslash).
  function automatic void put_osc(string s);
    put_byte(CH_ESC);
    put_byte(CH_OSC);
    put_str(s);
    if ($urandom_range(0, 1)) put_byte(CH_BEL);
    else begin
      put_byte(CH_ESC);
      put_byte(CH_BSL);
    end
  endfunction

  function automatic string rand_text(int max_len);
    string s;
    int n;
    byte c;
    s = "";
    n = $urandom_range(0, max_len);
    for (int k = 0; k < n; k++) begin
      c = byte'($urandom_range(8'h20, 8'h7E));
      if (c == CH_SEMI && $urandom_range(0, 1)) c = "x";
      s = {s, string'(c)};
    end
    return s;
  endfunction

  function automatic void rand_sequence();
    int pick;
    string digits;
    pick = $urandom_range(0, 15);
    case (pick)
      0: put_osc("133;A");
      1: put_osc("133;B");
      2: put_osc("133;C");
      3: put_osc("133;D");
      4: begin
        digits = "";
        for (int k = $urandom_range(1, 8); k > 0; k--)
          digits = {digits, string'(byte'($urandom_range(CH_ZERO, CH_NINE)))};
        put_osc({"133;D;", digits, rand_text(3)});
      end
      5: put_osc({"9;", rand_text(20)});
      6: put_osc({"777;notify;", rand_text(12), ";", rand_text(12)});
      7: put_osc({"777;notify;", rand_text(12)});
      8: begin
        if ($urandom_range(0, 1)) put_osc({"0;", rand_text(30)});
        else put_osc({"2;", rand_text(30)});
      end
      9: put_osc({"9;4;", rand_text(4)});
      10: put_byte(CH_BEL);
      11: begin
        // stray ESC inside a string
        put_byte(CH_ESC); put_byte(CH_OSC); put_str({"2;", rand_text(5)});
        put_byte(CH_ESC); put_byte(8'($urandom_range(0, 255)));
      end
      12: put_osc(rand_text(10));
      default: begin
        // noise, biased toward ESC bytes
        for (int k = $urandom_range(1, 4); k > 0; k--)
          put_byte($urandom_range(0, 3) == 0 ? CH_ESC : 8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  // ---- driver ----
  int in_wait = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata  <= '0;
      in_tlast  <= 0;
    end else if (in_tvalid && !in_tready) begin
      // hold the beat
    end else begin
      if (in_tvalid) begin
        predict_byte(in_tdata, in_tlast);
        in_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      end
      if (in_wait > 0 || byte_queue.size() == 0) begin
        if (in_wait > 0) in_wait--;
        in_tvalid <= 0;
      end else begin
        term_beat_t t;
        t = byte_queue.pop_front();
        in_tvalid <= 1;
        in_tdata  <= t.data;
        in_tlast  <= t.last;
      end
    end
  end

  // ---- monitor ----
  int out_wait = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        hit_beat_t want;
        if (hit_queue.size() == 0) begin
          report("unexpected beat", out_tdata, 64'd0);
        end else begin
          want = hit_queue.pop_front();
          if (out_tuser[2:0] != want.kind)
            report("mark_kind", 64'(out_tuser[2:0]), 64'(want.kind));
          if (out_tdata[17:0] != want.code)
            report("exit_code", 64'(out_tdata[17:0]), 64'(want.code));
          if (out_tdata[49:18] != want.end_off)
            report("end_offset", 64'(out_tdata[49:18]), 64'(want.end_off));
          if (out_tdata[57:50] != want.ch)
            report("text_char", 64'(out_tdata[57:50]), 64'(want.ch));
          if (out_tuser[3] != want.ch_valid)
            report("text_valid", 64'(out_tuser[3]), 64'(want.ch_valid));
          if (out_tlast != want.last)
            report("last_of_hit", 64'(out_tlast), 64'(want.last));
        end
        out_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      end
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    sh_in_osc = 0; sh_esc = 0; sh_len = 0; sh_ovf = 0; sh_offset = 0;
    rst_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed: bell, prompt, done, notify and title kinds, edge cases; put_osc picks the terminator at random
    put_byte(CH_BEL);
    put_osc("133;A"); put_osc("133;D");
    put_osc("133;D;0"); put_osc("133;D;99999999"); put_osc("133;Z");
    put_osc("9;hello"); put_osc("9;4;1;50");
    put_osc("777;notify;T;body"); put_osc("777;notify;T;");
    put_osc("0;win"); put_osc("2;");
    put_str({"\033", "x", "\007"});            // ESC swallows next byte, the bell still hits
    put_str({"\033\033]", "2;t", "\007"});       // ESC ESC stays armed
    put_str({"\033]2;ab\033Q"});                 // abandoned string
    // zero byte stops text
    put_byte(CH_ESC); put_byte(CH_OSC); put_str("2;a"); put_byte(8'h00);
    put_str("b"); put_byte(CH_BEL);
    put_byte(8'hFF); put_byte(8'h00);

    while (byte_queue.size() < 180) rand_sequence();

    wait (byte_queue.size() == 0 && !in_tvalid);
    wait (hit_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && hit_queue.size() == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
hdl/osp_pkg.sv
hdl/osp_ram.sv
hdl/osc_mark_stream_parser.sv
test/testbench.sv
